@@ rtl/u2a_pkg.sv @@
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types and character constants for the unsigned-to-ASCII converter.
// ----------------------------------------------------------------------------
package u2a_pkg;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CONV   = 5'b00010,
        ST_PFX0   = 5'b00100,
        ST_PFXX   = 5'b01000,
        ST_DIGITS = 5'b10000
    } state_t;

    localparam logic [6:0] CHAR_ZERO     = 7'h30;
    localparam logic [6:0] CHAR_NINE     = 7'h39;
    localparam logic [6:0] CHAR_LETTER_A = 7'h61;
    localparam logic [6:0] CHAR_LETTER_F = 7'h66;
    localparam logic [6:0] CHAR_X        = 7'h78;

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            c = CHAR_LETTER_A + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

@@ rtl/unsigned_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Unsigned value to ASCII text, decimal or lowercase hex with 0x prefix.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low; characters then appear
// one per strobe, most significant first, with last set on the final one.
// Decimal mode runs a bit-serial shift-add-3 conversion over VALUE_BITS bits,
// then walks the BCD digits one per cycle, skipping leading zeros. Hex mode
// skips the conversion: it sends the 0 and x prefix characters, then walks the
// nibbles one per cycle, also skipping leading zeros.
// Characters cannot be held off by the receiver; take each on its strobe.
module unsigned_to_ascii_digits #(
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    input  logic        hex_mode,
    output logic        strobe,
    output logic [6:0]  char_code,
    output logic        last
);
    import u2a_pkg::*;

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_BITS   = NDIG * 4;
    localparam int HEX_SHIFT  = DIG_BITS - HEX_DIGITS * 4;
    localparam int BCNT_W     = $clog2(VALUE_BITS + 1);
    localparam int DCNT_W     = $clog2(NDIG + 1);

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   src_reg, src_next;
    logic [DIG_BITS-1:0]     dig_reg, dig_next;
    logic [DIG_BITS-1:0]     adj;
    logic [BCNT_W-1:0]       bcnt_reg, bcnt_next;
    logic [DCNT_W-1:0]       dcnt_reg, dcnt_next;
    logic                    seen_reg, seen_next;
    logic                    strobe_reg, strobe_next;
    logic [6:0]              char_reg, char_next;
    logic                    last_reg, last_next;
    logic [3:0]              top;

    assign top = dig_reg[DIG_BITS-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[i*4 +: 4] inside {[4'd5:4'd15]})
            begin
                adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = dig_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        src_next    = src_reg;
        dig_next    = dig_reg;
        bcnt_next   = bcnt_reg;
        dcnt_next   = dcnt_reg;
        seen_next   = seen_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    seen_next = 1'b0;
                    if (hex_mode)
                    begin
                        dig_next   = DIG_BITS'(value[VALUE_BITS-1:0]) << HEX_SHIFT;
                        dcnt_next  = DCNT_W'(HEX_DIGITS);
                        state_next = ST_PFX0;
                    end
                    else
                    begin
                        src_next   = value[VALUE_BITS-1:0];
                        dig_next   = '0;
                        bcnt_next  = BCNT_W'(VALUE_BITS);
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next  = {adj[DIG_BITS-2:0], src_reg[VALUE_BITS-1]};
                src_next  = src_reg << 1;
                bcnt_next = bcnt_reg - 1'b1;
                if (bcnt_reg == BCNT_W'(1))
                begin
                    dcnt_next  = DCNT_W'(NDIG);
                    state_next = ST_DIGITS;
                end
            end
            ST_PFX0:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_ZERO;
                last_next   = 1'b0;
                state_next  = ST_PFXX;
            end
            ST_PFXX:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_X;
                last_next   = 1'b0;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                dig_next  = dig_reg << 4;
                dcnt_next = dcnt_reg - 1'b1;
                if (seen_reg || top != 4'd0 || dcnt_reg == DCNT_W'(1))
                begin
                    seen_next   = 1'b1;
                    strobe_next = 1'b1;
                    char_next   = glyph(top);
                    last_next   = (dcnt_reg == DCNT_W'(1));
                    if (dcnt_reg == DCNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bcnt_reg   <= '0;
            dcnt_reg   <= '0;
            seen_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bcnt_reg   <= bcnt_next;
            dcnt_reg   <= dcnt_next;
            seen_reg   <= seen_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

@@ rtl/u2a_checker.sv @@
// ----------------------------------------------------------------------------
// u2a_checker
// Port-level checks for the unsigned-to-ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
module u2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [6:0] char_code,
    input logic       last
);
    import u2a_pkg::*;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted value did not raise busy");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("idle before last beat of a value");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("beat right after last beat");

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && char_code == CHAR_X |-> $past(strobe) && $past(char_code) == CHAR_ZERO
            && !last)
        else $error("x not preceded by 0 or marked last");

    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
            || (char_code >= CHAR_LETTER_A && char_code <= CHAR_LETTER_F)
            || char_code == CHAR_X)
        else $error("character outside digit set");

endmodule

bind unsigned_to_ascii_digits u2a_checker u_u2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
);
